// ===== rtl/itoa_pkg.sv =====
// Shared types, constants and helpers for the integer to ASCII formatter.
package itoa_pkg;

	// Default cap on the field width.
	localparam int unsigned MAX_FIELD_WIDTH_DEF = 64;

	// Operand and digit register geometry.
	localparam int unsigned VALUE_W = 64;
	localparam int unsigned SLOTS = 24;
	localparam int unsigned SLOT_W = SLOTS * 4;
	localparam int unsigned ND_W = 5;
	localparam int unsigned DABBLE_STEPS = VALUE_W;
	localparam int unsigned STEP_W = 6;

	// Radix codes; any other code prints as hexadecimal.
	localparam logic [1:0] RADIX_DEC = 2'd0;
	localparam logic [1:0] RADIX_OCT = 2'd1;
	localparam logic [1:0] RADIX_HEX = 2'd2;

	// ASCII codes.
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_NORM,
		ST_EMIT
	} state_t;

	// Commands to the digit register.
	typedef enum logic [2:0] {
		DG_HOLD,
		DG_LOAD_BIN,
		DG_LOAD_OCT,
		DG_LOAD_HEX,
		DG_DABBLE,
		DG_SHIFT
	} dg_cmd_t;

	// Control word from the sequencer to the digit register.
	typedef struct packed {
		dg_cmd_t cmd;
		logic [VALUE_W-1:0] mag;
	} dg_ctl_t;

	// Maps a digit value to its ASCII character.
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + {4'd0, d};
		end else if (upper) begin
			c = CHAR_UPPER_A + {4'd0, d - 4'd10};
		end else begin
			c = CHAR_LOWER_A + {4'd0, d - 4'd10};
		end
		return c;
	endfunction

endpackage

// ===== rtl/itoa_digits.sv =====
// Digit register: loads octal or hex digits directly, builds decimal digits by
// shift-and-add-3, and shifts digits out most significant first.
module itoa_digits (
	input  logic                 clk,
	input  itoa_pkg::dg_ctl_t    ctl,
	output logic [3:0]           top_digit
);

	logic [itoa_pkg::SLOT_W-1:0]  digits_q;
	logic [itoa_pkg::VALUE_W-1:0] bin_q;
	logic [itoa_pkg::SLOT_W-1:0]  corrected;
	logic [itoa_pkg::SLOT_W-1:0]  oct_load;
	logic [itoa_pkg::SLOT_W-1:0]  hex_load;
	logic [3*itoa_pkg::SLOTS-1:0] oct_src;

	// Add 3 to every BCD digit of 5 or more before the next shift.
	always_comb begin
		for (int i = 0; i < itoa_pkg::SLOTS; i++) begin
			if (digits_q[4*i +: 4] >= 4'd5) begin
				corrected[4*i +: 4] = digits_q[4*i +: 4] + 4'd3;
			end else begin
				corrected[4*i +: 4] = digits_q[4*i +: 4];
			end
		end
	end

	// Split the magnitude into 3-bit or 4-bit digits.
	assign oct_src = {{(3*itoa_pkg::SLOTS-itoa_pkg::VALUE_W){1'b0}}, ctl.mag};
	assign hex_load = {{(itoa_pkg::SLOT_W-itoa_pkg::VALUE_W){1'b0}}, ctl.mag};

	always_comb begin
		for (int i = 0; i < itoa_pkg::SLOTS; i++) begin
			oct_load[4*i +: 4] = {1'b0, oct_src[3*i +: 3]};
		end
	end

	// Digit register update under the sequencer's command.
	always_ff @(posedge clk) begin
		case (ctl.cmd)
			itoa_pkg::DG_LOAD_BIN: begin
				digits_q <= '0;
				bin_q <= ctl.mag;
			end
			itoa_pkg::DG_LOAD_OCT: begin
				digits_q <= oct_load;
			end
			itoa_pkg::DG_LOAD_HEX: begin
				digits_q <= hex_load;
			end
			itoa_pkg::DG_DABBLE: begin
				digits_q <= {corrected[itoa_pkg::SLOT_W-2:0], bin_q[itoa_pkg::VALUE_W-1]};
				bin_q <= {bin_q[itoa_pkg::VALUE_W-2:0], 1'b0};
			end
			itoa_pkg::DG_SHIFT: begin
				digits_q <= {digits_q[itoa_pkg::SLOT_W-5:0], 4'd0};
			end
			default: begin
			end
		endcase
	end

	assign top_digit = digits_q[itoa_pkg::SLOT_W-1 -: 4];

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter.
//
// A number with its format settings is taken when start is high and busy is
// low. The block then stays busy until its last character has been sent.
// Characters leave one per cycle on character, marked by strobe, most
// significant first; last marks the final character of the number. The
// receiver has no way to hold characters off, and none is needed.
//
// Sequence: decimal numbers first run the shift-and-add-3 loop of the digit
// register over every operand bit; octal and hex skip it. Then leading zero
// digits are dropped one per cycle, keeping at least one, padding is settled,
// and the text goes out at one character per cycle, at most MAX_FIELD_WIDTH
// or 23 characters, whichever is more. A new number can be taken in the
// cycle after the last character has been produced. All digit steps run in
// the single digit register instance.
//
// Reset clears the sequencer and the strobe; no characters appear until a
// number is started.
module integer_to_ascii_formatter #(
	parameter int unsigned MAX_FIELD_WIDTH = itoa_pkg::MAX_FIELD_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] value,
	input  logic [1:0]  radix,
	input  logic        upper_case,
	input  logic        is_signed,
	input  logic        long_operand,
	input  logic [6:0]  min_width,
	input  logic        zero_pad,
	output logic [7:0]  character,
	output logic        last,
	output logic        strobe
);

	localparam int unsigned CW = $clog2(MAX_FIELD_WIDTH + 1);

	itoa_pkg::state_t state_q, state_d;
	logic [itoa_pkg::STEP_W-1:0] cnt_q, cnt_d;
	logic [itoa_pkg::ND_W-1:0]   nd_q, nd_d;
	logic                        neg_q, neg_d;
	logic                        upper_q, upper_d;
	logic                        zpad_q, zpad_d;
	logic [CW-1:0]               fw_q, fw_d;
	logic [CW-1:0]               pad_q, pad_d;
	logic [CW-1:0]               rem_q, rem_d;
	logic [7:0]                  character_q, character_d;
	logic                        last_q, last_d;
	logic                        strobe_q, strobe_d;

	logic [itoa_pkg::VALUE_W-1:0] ext_val;
	logic                         in_neg;
	logic [CW-1:0]                text_len;
	logic [CW-1:0]                total;
	logic [3:0]                   top_digit;
	itoa_pkg::dg_ctl_t            dg_ctl;

	// Operand extension and magnitude.
	assign ext_val = long_operand ? value
		: {{32{is_signed & value[31]}}, value[31:0]};
	assign in_neg = is_signed & ext_val[itoa_pkg::VALUE_W-1];

	// Text length and padded total once the digit count is known.
	assign text_len = CW'(nd_q) + CW'(neg_q);
	assign total = (fw_q > text_len) ? fw_q : text_len;

	itoa_digits u_digits (
		.clk       (clk),
		.ctl       (dg_ctl),
		.top_digit (top_digit)
	);

	// Sequencer: next state, digit register commands and output word.
	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		nd_d = nd_q;
		neg_d = neg_q;
		upper_d = upper_q;
		zpad_d = zpad_q;
		fw_d = fw_q;
		pad_d = pad_q;
		rem_d = rem_q;
		character_d = character_q;
		last_d = 1'b0;
		strobe_d = 1'b0;
		dg_ctl.cmd = itoa_pkg::DG_HOLD;
		dg_ctl.mag = in_neg ? (64'd0 - ext_val) : ext_val;
		case (state_q)
			itoa_pkg::ST_IDLE: begin
				if (start) begin
					neg_d = in_neg;
					upper_d = upper_case;
					zpad_d = zero_pad;
					fw_d = (min_width > 7'(MAX_FIELD_WIDTH)) ? CW'(MAX_FIELD_WIDTH)
						: CW'(min_width);
					nd_d = itoa_pkg::ND_W'(itoa_pkg::SLOTS);
					cnt_d = itoa_pkg::STEP_W'(itoa_pkg::DABBLE_STEPS - 1);
					case (radix)
						itoa_pkg::RADIX_DEC: begin
							dg_ctl.cmd = itoa_pkg::DG_LOAD_BIN;
							state_d = itoa_pkg::ST_CONV;
						end
						itoa_pkg::RADIX_OCT: begin
							dg_ctl.cmd = itoa_pkg::DG_LOAD_OCT;
							state_d = itoa_pkg::ST_NORM;
						end
						default: begin
							dg_ctl.cmd = itoa_pkg::DG_LOAD_HEX;
							state_d = itoa_pkg::ST_NORM;
						end
					endcase
				end
			end
			itoa_pkg::ST_CONV: begin
				dg_ctl.cmd = itoa_pkg::DG_DABBLE;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					state_d = itoa_pkg::ST_NORM;
				end
			end
			itoa_pkg::ST_NORM: begin
				// Drop leading zero digits, keeping at least one.
				if (top_digit == 4'd0 && nd_q != itoa_pkg::ND_W'(1)) begin
					dg_ctl.cmd = itoa_pkg::DG_SHIFT;
					nd_d = nd_q - 1'b1;
				end else begin
					pad_d = total - text_len;
					rem_d = total;
					state_d = itoa_pkg::ST_EMIT;
				end
			end
			itoa_pkg::ST_EMIT: begin
				strobe_d = 1'b1;
				last_d = (rem_q == CW'(1));
				rem_d = rem_q - 1'b1;
				if (!zpad_q && pad_q != '0) begin
					character_d = itoa_pkg::CHAR_SPACE;
					pad_d = pad_q - 1'b1;
				end else if (neg_q) begin
					character_d = itoa_pkg::CHAR_MINUS;
					neg_d = 1'b0;
				end else if (pad_q != '0) begin
					character_d = itoa_pkg::CHAR_ZERO;
					pad_d = pad_q - 1'b1;
				end else begin
					character_d = itoa_pkg::digit_char(top_digit, upper_q);
					dg_ctl.cmd = itoa_pkg::DG_SHIFT;
				end
				if (rem_q == CW'(1)) begin
					state_d = itoa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = itoa_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itoa_pkg::ST_IDLE;
			strobe_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe_q <= strobe_d;
			last_q <= last_d;
		end
	end

	// Working and output word registers.
	always_ff @(posedge clk) begin
		cnt_q <= cnt_d;
		nd_q <= nd_d;
		neg_q <= neg_d;
		upper_q <= upper_d;
		zpad_q <= zpad_d;
		fw_q <= fw_d;
		pad_q <= pad_d;
		rem_q <= rem_d;
		character_q <= character_d;
	end

	assign busy = (state_q != itoa_pkg::ST_IDLE);
	assign character = character_q;
	assign last = last_q;
	assign strobe = strobe_q;

endmodule

// ===== rtl/itoa_checker.sv =====
// Port-level checks for the integer to ASCII formatter, bound to its top level.
module itoa_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic last
);

	// An accepted number makes the block busy in the next cycle.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after accepting a number");

	// No word goes out in the cycle right after a number is accepted.
	a_no_early_word: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !strobe)
		else $error("word strobed right after acceptance");

	// Characters of one number come out back to back until the last one.
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap inside the text of a number");

	// A word that is not the last keeps the block busy.
	a_busy_mid_text: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("block idle in the middle of a number");

	// The last flag only comes with a word.
	a_last_with_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe)
		else $error("last flag without a word");

endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.strobe (strobe),
	.last   (last)
);
